>>> hdl/idpa_pkg.sv
// Shared constants for the identifier pool allocator.
// Holds default sizes, field widths, status codes and register indexes.
// Depends on nothing.
`timescale 1ns / 1ps

package idpa_pkg;

    localparam int ID_WIDTH_DEF   = 16;
    localparam int FREE_DEPTH_DEF = 1024;

    localparam int CNT_W    = 17;
    localparam int MIN_W    = 17;
    localparam int STATUS_W = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 1;

    localparam logic [APB_AW-1:0] REG_REUSE_THRESH = 1'b0;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_ACTIVE = 2'd3;

endpackage

>>> hdl/id_pool_allocator.sv
// Identifier pool allocator: fresh counter plus a FIFO of released identifiers.
// The FIFO lives in a single synchronous memory with a registered read.
// Depends on idpa_pkg.
`timescale 1ns / 1ps

// Usage:
// Requests enter on the input channel (i_in_valid / o_in_ready) with i_func
// selecting allocate or release. Every request gives exactly one result on
// the output channel (o_out_valid / i_out_ready): the granted identifier,
// the active count after the request, and a status code.
// An allocate served from the fresh counter, a release, and any failed
// request deliver their result in the cycle after acceptance. An allocate that
// pops the free queue passes through the registered read of the free-queue
// memory and then the output register; the input is not ready during the read.
// A new request is taken in the same cycle that the previous result is
// consumed, so the block sustains one transaction per cycle while the receiver
// does not stall, except for pops, which hold the input not ready for the read.
// If the receiver stalls, the result stays in the output register and no
// new request is taken until it leaves.
// Reset holds the input not ready, empties the queue, zeroes the counters and
// clears the reuse threshold. The queue memory is not cleared; only written
// entries are ever read. The reuse threshold is written over APB at byte address
// 0 only while idle; the user must keep to this, the block does not enforce it.
module id_pool_allocator #(
    parameter int ID_WIDTH   = idpa_pkg::ID_WIDTH_DEF,
    parameter int FREE_DEPTH = idpa_pkg::FREE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [ID_WIDTH-1:0]           i_release_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ID_WIDTH-1:0]           o_granted_id,
    output logic [idpa_pkg::CNT_W-1:0]    o_active_count,
    output logic [idpa_pkg::STATUS_W-1:0] o_status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [idpa_pkg::APB_AW-1:0]   paddr,
    input  logic [idpa_pkg::APB_DW-1:0]   pwdata,
    output logic [idpa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int PTR_W   = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(FREE_DEPTH + 1);
    localparam int FRESH_W = ID_WIDTH + 1;
    localparam int CMP_W   = (FRESH_W > idpa_pkg::MIN_W) ? FRESH_W : idpa_pkg::MIN_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [ID_WIDTH-1:0] r_mem [FREE_DEPTH];
    logic [ID_WIDTH-1:0] r_rd_data;

    logic                          r_state, n_state;
    logic                          r_out_valid, n_out_valid;
    logic [ID_WIDTH-1:0]           r_granted, n_granted;
    logic [idpa_pkg::CNT_W-1:0]    r_count_out, n_count_out;
    logic [idpa_pkg::STATUS_W-1:0] r_status, n_status;
    logic [FRESH_W-1:0]            r_fresh, n_fresh;
    logic [idpa_pkg::CNT_W-1:0]    r_active, n_active;
    logic [PTR_W-1:0]              r_rptr, n_rptr;
    logic [PTR_W-1:0]              r_wptr, n_wptr;
    logic [FILL_W-1:0]             r_fill, n_fill;
    logic [idpa_pkg::MIN_W-1:0]    r_reuse_thresh;

    logic in_acc;
    logic fresh_sel;
    logic mem_we;
    logic mem_re;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready &&
                    (paddr == idpa_pkg::REG_REUSE_THRESH);
    assign prdata = (paddr == idpa_pkg::REG_REUSE_THRESH) ?
                    idpa_pkg::APB_DW'(r_reuse_thresh) : '0;

    assign o_in_ready     = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc         = i_in_valid && o_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_granted_id   = r_granted;
    assign o_active_count = r_count_out;
    assign o_status       = r_status;

    assign fresh_sel = (r_fill == '0) || (CMP_W'(r_fresh) < CMP_W'(r_reuse_thresh));

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_granted   = r_granted;
        n_count_out = r_count_out;
        n_status    = r_status;
        n_fresh     = r_fresh;
        n_active    = r_active;
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (r_state == S_READ) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_granted   = r_rd_data;
            n_count_out = r_active;
            n_status    = idpa_pkg::ST_OK;
        end else if (in_acc) begin
            n_granted = '0;
            n_status  = idpa_pkg::ST_OK;
            unique case (i_func)
                idpa_pkg::FUNC_ALLOC: begin
                    if (fresh_sel) begin
                        n_out_valid = 1'b1;
                        if (r_fresh[ID_WIDTH]) begin
                            n_status = idpa_pkg::ST_EXHAUSTED;
                        end else begin
                            n_granted = r_fresh[ID_WIDTH-1:0];
                            n_fresh   = r_fresh + FRESH_W'(1);
                            n_active  = r_active + idpa_pkg::CNT_W'(1);
                        end
                    end else begin
                        mem_re   = 1'b1;
                        n_state  = S_READ;
                        n_rptr   = (r_rptr == PTR_W'(FREE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
                        n_fill   = r_fill - FILL_W'(1);
                        n_active = r_active + idpa_pkg::CNT_W'(1);
                    end
                end
                idpa_pkg::FUNC_RELEASE: begin
                    n_out_valid = 1'b1;
                    if (r_active == '0) begin
                        n_status = idpa_pkg::ST_NONE_ACTIVE;
                    end else if (r_fill == FILL_W'(FREE_DEPTH)) begin
                        n_status = idpa_pkg::ST_FULL;
                    end else begin
                        mem_we   = 1'b1;
                        n_wptr   = (r_wptr == PTR_W'(FREE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
                        n_fill   = r_fill + FILL_W'(1);
                        n_active = r_active - idpa_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    n_out_valid = r_out_valid;
                end
            endcase
            n_count_out = n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wptr] <= i_release_id;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_fresh        <= '0;
            r_active       <= '0;
            r_rptr         <= '0;
            r_wptr         <= '0;
            r_fill         <= '0;
            r_reuse_thresh <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fresh     <= n_fresh;
            r_active    <= n_active;
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            if (cfg_we) begin
                r_reuse_thresh <= pwdata[idpa_pkg::MIN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_granted   <= n_granted;
        r_count_out <= n_count_out;
        r_status    <= n_status;
    end

endmodule
